// File: src/page_replacement_engine_top_macros.svh
// Assertion macros used by the page replacement engine sequencer (pre_ctrl).
`ifndef PAGE_REPLACEMENT_ENGINE_TOP_MACROS_SVH
`define PAGE_REPLACEMENT_ENGINE_TOP_MACROS_SVH
// Same-cycle implication, checked outside reset.
`define PRE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define PRE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: src/pre_pkg.sv
// ----------------------------------------------------------------------------
// pre_pkg
// Types, codes and constants shared by the page replacement engine.
// ----------------------------------------------------------------------------
`default_nettype none
package pre_pkg;
    localparam int FRAMES_DEF     = 32;
    localparam int PAGE_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int IN_PAGE_W      = 16;
    localparam int FAULT_W        = 32;
    localparam int CFG_DATA_W     = 6;
    localparam int SLOT_W_MAX     = 6;
    localparam int FCNT_W_MAX     = 7;

    typedef enum logic [1:0] {POL_FIFO, POL_LRU, POL_LFU, POL_CLOCK} t_policy;
    typedef enum logic {CFG_POLICY, CFG_FRAMES} t_cfg_idx;
    typedef enum logic [2:0] {
        OP_NONE, OP_HIT, OP_LRU_HIT, OP_REFILL, OP_LRU_MISS, OP_CLR_REF, OP_CLEAR
    } t_op;
    typedef enum logic [2:0] {S_IDLE, S_MATCH, S_SCAN, S_COMMIT, S_DONE} t_state;

    typedef struct packed {
        t_op                   op;
        logic [SLOT_W_MAX-1:0] slot;
        logic [FCNT_W_MAX-1:0] fcnt;
    } t_store_cmd;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_W_MAX-1:0] hit_slot;
        logic                  empty;
        logic [SLOT_W_MAX-1:0] empty_slot;
    } t_store_stat;
endpackage
`default_nettype wire

// File: src/pre_req_if.sv
// ----------------------------------------------------------------------------
// pre_req_if
// Page reference channel: valid/ready with page number and last flag.
// ----------------------------------------------------------------------------
`default_nettype none
interface pre_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] page_number;
    logic        last_reference;
    modport source (output valid, page_number, last_reference, input ready);
    modport sink (input valid, page_number, last_reference, output ready);
endinterface
`default_nettype wire

// File: src/pre_rsp_if.sv
// ----------------------------------------------------------------------------
// pre_rsp_if
// Result channel: valid/ready with hit, victim and fault count.
// ----------------------------------------------------------------------------
`default_nettype none
interface pre_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic        victim_valid;
    logic [15:0] victim_page;
    logic [31:0] fault_count;
    modport source (output valid, hit, victim_valid, victim_page, fault_count, input ready);
    modport sink (input valid, hit, victim_valid, victim_page, fault_count, output ready);
endinterface
`default_nettype wire

// File: src/pre_store.sv
// ----------------------------------------------------------------------------
// pre_store
// Frame lanes: page, valid, use count and reference bit per frame, with
// parallel match, first-empty search and the per-policy update operations.
// ----------------------------------------------------------------------------
`default_nettype none
module pre_store #(
    parameter int FRAMES     = pre_pkg::FRAMES_DEF,
    parameter int PAGE_BITS  = pre_pkg::PAGE_BITS_DEF,
    parameter int COUNT_BITS = pre_pkg::COUNT_BITS_DEF,
    localparam int IDX_W     = $clog2(FRAMES)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire pre_pkg::t_store_cmd     i_cmd,
    input  wire logic [PAGE_BITS-1:0]    i_page,
    input  wire logic [IDX_W-1:0]        i_rd_idx,
    output pre_pkg::t_store_stat         o_stat,
    output logic                         o_rd_valid,
    output logic                         o_rd_ref,
    output logic [PAGE_BITS-1:0]         o_rd_page,
    output logic [COUNT_BITS-1:0]        o_rd_count
);
    import pre_pkg::*;
    localparam int F_W = $clog2(FRAMES + 1);

    logic [PAGE_BITS-1:0]  r_page  [FRAMES];
    logic                  r_valid [FRAMES];
    logic [COUNT_BITS-1:0] r_count [FRAMES];
    logic                  r_ref   [FRAMES];

    logic [F_W-1:0]        f;
    logic [F_W-1:0]        f_m1;
    logic [IDX_W-1:0]      last_idx;
    logic [IDX_W-1:0]      slot;
    logic                  hit;
    logic [IDX_W-1:0]      hit_slot;
    logic                  empty;
    logic [IDX_W-1:0]      empty_slot;
    logic [PAGE_BITS-1:0]  sel_page;
    logic [COUNT_BITS-1:0] sel_count;
    logic [COUNT_BITS-1:0] sel_inc;

    assign f        = i_cmd.fcnt[F_W-1:0];
    assign f_m1     = f - F_W'(1);
    assign last_idx = f_m1[IDX_W-1:0];
    assign slot     = i_cmd.slot[IDX_W-1:0];

    // Lowest matching and lowest empty frame among the active ones.
    always_comb begin
        hit        = 1'b0;
        hit_slot   = '0;
        empty      = 1'b0;
        empty_slot = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (F_W'(i) < f && r_valid[i] && r_page[i] == i_page) begin
                hit      = 1'b1;
                hit_slot = IDX_W'(i);
            end
            if (F_W'(i) < f && !r_valid[i]) begin
                empty      = 1'b1;
                empty_slot = IDX_W'(i);
            end
        end
    end

    assign o_stat.hit        = hit;
    assign o_stat.hit_slot   = SLOT_W_MAX'(hit_slot);
    assign o_stat.empty      = empty;
    assign o_stat.empty_slot = SLOT_W_MAX'(empty_slot);

    assign o_rd_valid = r_valid[i_rd_idx];
    assign o_rd_ref   = r_ref[i_rd_idx];
    assign o_rd_page  = r_page[i_rd_idx];
    assign o_rd_count = r_count[i_rd_idx];

    assign sel_page  = r_page[slot];
    assign sel_count = r_count[slot];
    assign sel_inc   = (&sel_count) ? sel_count : sel_count + COUNT_BITS'(1);

    for (genvar g = 0; g < FRAMES; g++) begin : g_lane
        logic [PAGE_BITS-1:0]  nb_page;
        logic                  nb_valid;
        logic [COUNT_BITS-1:0] nb_count;
        logic                  nb_ref;
        logic [COUNT_BITS-1:0] own_inc;

        if (g < FRAMES - 1) begin : g_nb
            assign nb_page  = r_page[g+1];
            assign nb_valid = r_valid[g+1];
            assign nb_count = r_count[g+1];
            assign nb_ref   = r_ref[g+1];
        end else begin : g_edge
            assign nb_page  = r_page[g];
            assign nb_valid = r_valid[g];
            assign nb_count = r_count[g];
            assign nb_ref   = r_ref[g];
        end

        assign own_inc = (&r_count[g]) ? r_count[g] : r_count[g] + COUNT_BITS'(1);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_page[g]  <= '0;
                r_valid[g] <= 1'b0;
                r_count[g] <= '0;
                r_ref[g]   <= 1'b0;
            end else begin
                case (i_cmd.op)
                    OP_CLEAR: begin
                        r_page[g]  <= '0;
                        r_valid[g] <= 1'b0;
                        r_count[g] <= '0;
                        r_ref[g]   <= 1'b0;
                    end
                    OP_HIT: begin
                        if (slot == IDX_W'(g)) begin
                            r_count[g] <= own_inc;
                            r_ref[g]   <= 1'b1;
                        end
                    end
                    OP_CLR_REF: begin
                        if (slot == IDX_W'(g)) begin
                            r_ref[g] <= 1'b0;
                        end
                    end
                    OP_REFILL: begin
                        if (slot == IDX_W'(g)) begin
                            r_page[g]  <= i_page;
                            r_valid[g] <= 1'b1;
                            r_count[g] <= COUNT_BITS'(1);
                            r_ref[g]   <= 1'b1;
                        end
                    end
                    OP_LRU_HIT: begin
                        if (IDX_W'(g) >= slot && IDX_W'(g) < last_idx) begin
                            r_page[g]  <= nb_page;
                            r_valid[g] <= nb_valid;
                            r_count[g] <= nb_count;
                            r_ref[g]   <= nb_ref;
                        end else if (IDX_W'(g) == last_idx) begin
                            r_page[g]  <= sel_page;
                            r_valid[g] <= 1'b1;
                            r_count[g] <= sel_inc;
                            r_ref[g]   <= 1'b1;
                        end
                    end
                    OP_LRU_MISS: begin
                        if (IDX_W'(g) < last_idx) begin
                            r_page[g]  <= nb_page;
                            r_valid[g] <= nb_valid;
                            r_count[g] <= nb_count;
                            r_ref[g]   <= nb_ref;
                        end else if (IDX_W'(g) == last_idx) begin
                            r_page[g]  <= i_page;
                            r_valid[g] <= 1'b1;
                            r_count[g] <= COUNT_BITS'(1);
                            r_ref[g]   <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// File: src/pre_ctrl.sv
// ----------------------------------------------------------------------------
// pre_ctrl
// Sequencer: match, victim search (LFU scan, CLOCK sweep), refill and the
// pointers and fault counter that go with them.
// ----------------------------------------------------------------------------
`default_nettype none
module pre_ctrl #(
    parameter int FRAMES     = pre_pkg::FRAMES_DEF,
    parameter int PAGE_BITS  = pre_pkg::PAGE_BITS_DEF,
    parameter int COUNT_BITS = pre_pkg::COUNT_BITS_DEF,
    localparam int IDX_W     = $clog2(FRAMES)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [15:0]           i_in_page,
    input  wire logic                  i_in_last,
    input  wire pre_pkg::t_policy      i_policy,
    input  wire logic [5:0]            i_frames,
    input  wire logic                  i_frames_all,
    output pre_pkg::t_store_cmd        o_cmd,
    output logic [PAGE_BITS-1:0]       o_page,
    output logic [IDX_W-1:0]           o_rd_idx,
    input  wire pre_pkg::t_store_stat  i_stat,
    input  wire logic                  i_rd_valid,
    input  wire logic                  i_rd_ref,
    input  wire logic [PAGE_BITS-1:0]  i_rd_page,
    input  wire logic [COUNT_BITS-1:0] i_rd_count,
    output logic                       o_res_valid,
    input  wire logic                  i_res_ready,
    output logic                       o_res_hit,
    output logic                       o_res_vv,
    output logic [15:0]                o_res_vp,
    output logic [31:0]                o_res_fault
);
    import pre_pkg::*;
    `include "page_replacement_engine_top_macros.svh"
    localparam int F_W = $clog2(FRAMES + 1);

    t_state                r_state, n_state;
    logic [PAGE_BITS-1:0]  r_page;
    logic                  r_last;
    logic [IDX_W-1:0]      r_slot, r_scan, r_best, r_fifo, r_hand;
    logic [COUNT_BITS-1:0] r_best_cnt;
    logic [PAGE_BITS-1:0]  r_best_page;
    logic [31:0]           r_miss;
    logic                  r_hit, r_vv;
    logic [15:0]           r_vp;
    logic [31:0]           r_fault;

    logic [F_W-1:0]        f;
    logic [F_W-1:0]        f_m1;
    logic [IDX_W-1:0]      last_idx;
    logic [6:0]            fr7;
    logic [PAGE_BITS+15:0] in_ext;
    logic [PAGE_BITS+15:0] rd_ext;
    logic [31:0]           miss_inc;
    logic                  better;
    logic [IDX_W-1:0]      fifo_s, hand_s, fifo_nx, scan_nx;

    // Effective frame count: zero acts as one, above the store as all.
    assign fr7 = {1'b0, i_frames};
    always_comb begin
        if (i_frames_all || fr7 > 7'(FRAMES)) begin
            f = F_W'(FRAMES);
        end else if (fr7 == 7'd0) begin
            f = F_W'(1);
        end else begin
            f = F_W'(fr7);
        end
    end
    assign f_m1     = f - F_W'(1);
    assign last_idx = f_m1[IDX_W-1:0];

    assign in_ext   = {{PAGE_BITS{1'b0}}, i_in_page};
    assign rd_ext   = {16'd0, i_rd_page};
    assign miss_inc = (&r_miss) ? r_miss : r_miss + 32'd1;
    assign better   = (i_rd_count < r_best_cnt) ||
                      (i_rd_count == r_best_cnt && i_rd_page < r_best_page);

    assign fifo_s  = (F_W'(r_fifo) >= f) ? '0 : r_fifo;
    assign hand_s  = (F_W'(r_hand) >= f) ? '0 : r_hand;
    assign fifo_nx = (F_W'(fifo_s) + F_W'(1) == f) ? '0 : fifo_s + IDX_W'(1);
    assign scan_nx = (F_W'(r_scan) + F_W'(1) == f) ? '0 : r_scan + IDX_W'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_MATCH;
            end
            S_MATCH: begin
                if (i_stat.hit) begin
                    n_state = S_DONE;
                end else begin
                    case (i_policy)
                        POL_LFU: begin
                            if (i_stat.empty || last_idx == '0) n_state = S_COMMIT;
                            else n_state = S_SCAN;
                        end
                        POL_CLOCK: n_state = S_SCAN;
                        default:   n_state = S_COMMIT;
                    endcase
                end
            end
            S_SCAN: begin
                if (i_policy == POL_CLOCK) begin
                    if (!i_rd_ref) n_state = S_COMMIT;
                end else if (r_scan == last_idx) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: n_state = S_DONE;
            S_DONE: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op    = OP_NONE;
        o_cmd.slot  = '0;
        o_cmd.fcnt  = FCNT_W_MAX'(f);
        o_rd_idx    = r_scan;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_MATCH: begin
                o_rd_idx = '0;
                if (i_stat.hit) begin
                    o_cmd.op   = (i_policy == POL_LRU) ? OP_LRU_HIT : OP_HIT;
                    o_cmd.slot = i_stat.hit_slot;
                end
            end
            S_SCAN: begin
                if (i_policy == POL_CLOCK && i_rd_ref) begin
                    o_cmd.op   = OP_CLR_REF;
                    o_cmd.slot = SLOT_W_MAX'(r_scan);
                end
            end
            S_COMMIT: begin
                o_rd_idx   = (i_policy == POL_LRU) ? '0 : r_slot;
                o_cmd.op   = (i_policy == POL_LRU) ? OP_LRU_MISS : OP_REFILL;
                o_cmd.slot = SLOT_W_MAX'(r_slot);
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready && r_last) o_cmd.op = OP_CLEAR;
            end
            default: begin
            end
        endcase
    end

    assign o_page      = r_page;
    assign o_res_hit   = r_hit;
    assign o_res_vv    = r_vv;
    assign o_res_vp    = r_vp;
    assign o_res_fault = r_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fifo <= '0;
            r_hand <= '0;
            r_miss <= '0;
            r_last <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_page <= in_ext[PAGE_BITS-1:0];
                        r_last <= i_in_last;
                    end
                end
                S_MATCH: begin
                    r_hit   <= i_stat.hit;
                    r_vv    <= 1'b0;
                    r_vp    <= '0;
                    r_fault <= r_miss;
                    if (!i_stat.hit) begin
                        case (i_policy)
                            POL_FIFO: begin
                                r_slot <= fifo_s;
                                r_fifo <= fifo_nx;
                            end
                            POL_LRU: r_slot <= last_idx;
                            POL_LFU: begin
                                if (i_stat.empty) begin
                                    r_slot <= i_stat.empty_slot[IDX_W-1:0];
                                end else begin
                                    r_slot      <= '0;
                                    r_best      <= '0;
                                    r_best_cnt  <= i_rd_count;
                                    r_best_page <= i_rd_page;
                                    r_scan      <= IDX_W'(1);
                                end
                            end
                            default: r_scan <= hand_s;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (i_policy == POL_CLOCK) begin
                        if (i_rd_ref) begin
                            r_scan <= scan_nx;
                        end else begin
                            r_slot <= r_scan;
                            r_hand <= scan_nx;
                        end
                    end else begin
                        if (better) begin
                            r_best      <= r_scan;
                            r_best_cnt  <= i_rd_count;
                            r_best_page <= i_rd_page;
                        end
                        if (r_scan == last_idx) begin
                            r_slot <= better ? r_scan : r_best;
                        end else begin
                            r_scan <= r_scan + IDX_W'(1);
                        end
                    end
                end
                S_COMMIT: begin
                    r_vv    <= i_rd_valid;
                    r_vp    <= i_rd_valid ? rd_ext[15:0] : 16'd0;
                    r_miss  <= miss_inc;
                    r_fault <= miss_inc;
                end
                S_DONE: begin
                    if (i_res_ready && r_last) begin
                        r_fifo <= '0;
                        r_hand <= '0;
                        r_miss <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    `PRE_ASSERT_NEXT(a_hit_done, r_state == S_MATCH && i_stat.hit, r_state == S_DONE, "hit late")
    `PRE_ASSERT_NEXT(a_miss_mono, r_state != S_DONE, r_miss >= $past(r_miss), "fault count fell")
    `PRE_ASSERT_NOW(a_scan_range, r_state == S_SCAN, F_W'(r_scan) < f, "scan index out of range")
endmodule
`default_nettype wire

// File: src/page_replacement_engine_top.sv
// ----------------------------------------------------------------------------
// page_replacement_engine_top
// Fully associative page frame store with FIFO, LRU, LFU and CLOCK victims.
// ----------------------------------------------------------------------------
// Usage. Page references arrive as beats on i_req; each produces exactly one
// result beat on o_rsp with hit, victim and the running fault count.
// Policy and frame count are written through i_cfg_we/i_cfg_idx/i_cfg_data
// while the engine is idle. One reference is in flight at a time.
// From acceptance, a reference is matched; a miss then goes through a victim
// search where needed (an LFU scan of the active frames when none is empty and
// more than one is active, a CLOCK sweep past set reference bits) and a commit,
// and the result is parked in the output register for o_rsp. The next
// reference is taken once the sequencer has handed its result on.
// Reset: all frames empty, pointers and fault count zero, FIFO policy, all
// frames active. A beat with last_reference set clears the same state once
// its result is handed on; configuration is kept.
// Back-pressure: the result sits in an output register, so the next
// reference is accepted while it waits; a further result holds until the
// receiver takes the first.
// ----------------------------------------------------------------------------
`default_nettype none
module page_replacement_engine_top #(
    parameter int FRAMES     = pre_pkg::FRAMES_DEF,
    parameter int PAGE_BITS  = pre_pkg::PAGE_BITS_DEF,
    parameter int COUNT_BITS = pre_pkg::COUNT_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    pre_req_if.sink         i_req,
    pre_rsp_if.source       o_rsp,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [5:0] i_cfg_data
);
    import pre_pkg::*;
    localparam int IDX_W = $clog2(FRAMES);

    t_policy               r_policy;
    logic [5:0]            r_frames;
    logic                  r_frames_all;
    logic                  r_ovalid;
    logic                  r_ohit, r_ovv;
    logic [15:0]           r_ovp;
    logic [31:0]           r_ofault;

    t_store_cmd            cmd;
    t_store_stat           stat;
    logic [PAGE_BITS-1:0]  st_page;
    logic [IDX_W-1:0]      rd_idx;
    logic                  rd_valid, rd_ref;
    logic [PAGE_BITS-1:0]  rd_page;
    logic [COUNT_BITS-1:0] rd_count;
    logic                  res_valid, res_ready;
    logic                  res_hit, res_vv;
    logic [15:0]           res_vp;
    logic [31:0]           res_fault;

    // Configuration registers. Until the frame count is first written the
    // whole store takes part, whatever the store depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy     <= POL_FIFO;
            r_frames     <= '0;
            r_frames_all <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_POLICY: r_policy <= t_policy'(i_cfg_data[1:0]);
                CFG_FRAMES: begin
                    r_frames     <= i_cfg_data;
                    r_frames_all <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    pre_store #(
        .FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS), .COUNT_BITS(COUNT_BITS)
    ) u_store (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_page(st_page),
        .i_rd_idx(rd_idx), .o_stat(stat), .o_rd_valid(rd_valid), .o_rd_ref(rd_ref),
        .o_rd_page(rd_page), .o_rd_count(rd_count)
    );

    pre_ctrl #(
        .FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS), .COUNT_BITS(COUNT_BITS)
    ) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_req.valid), .o_in_ready(i_req.ready),
        .i_in_page(i_req.page_number), .i_in_last(i_req.last_reference),
        .i_policy(r_policy), .i_frames(r_frames), .i_frames_all(r_frames_all),
        .o_cmd(cmd), .o_page(st_page), .o_rd_idx(rd_idx), .i_stat(stat),
        .i_rd_valid(rd_valid), .i_rd_ref(rd_ref), .i_rd_page(rd_page),
        .i_rd_count(rd_count), .o_res_valid(res_valid), .i_res_ready(res_ready),
        .o_res_hit(res_hit), .o_res_vv(res_vv), .o_res_vp(res_vp),
        .o_res_fault(res_fault)
    );

    // Output register: frees the sequencer as soon as a result is parked.
    assign res_ready = !r_ovalid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_ohit   <= res_hit;
            r_ovv    <= res_vv;
            r_ovp    <= res_vp;
            r_ofault <= res_fault;
        end
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.hit          = r_ohit;
    assign o_rsp.victim_valid = r_ovv;
    assign o_rsp.victim_page  = r_ovp;
    assign o_rsp.fault_count  = r_ofault;
endmodule
`default_nettype wire

// File: test/page_replacement_checker.sv
// ----------------------------------------------------------------------------
// page_replacement_checker
// Watches the reference and result channels and the register port, keeps its
// own copy of the frame store and compares every result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module page_replacement_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    pre_req_if              i_req,
    pre_rsp_if              i_rsp,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [5:0] i_cfg_data,
    output int              o_errors,
    output int              o_pending,
    output int              o_hits
);
    import pre_pkg::*;

    localparam int NFR = 32;

    typedef struct packed {
        logic        hit;
        logic        victim_valid;
        logic [15:0] victim_page;
        logic [31:0] fault_count;
    } t_outcome;

    logic [15:0] pg [NFR];
    logic        vld [NFR];
    logic [15:0] uses [NFR];
    logic        refb [NFR];
    int          fifo_ptr;
    int          hand;
    logic [31:0] faults;
    t_policy     policy;
    logic [5:0]  nframes;

    t_outcome    outcomes_due[$];

    task automatic clear_frames();
        for (int i = 0; i < NFR; i++) begin
            pg[i] = '0; vld[i] = 1'b0; uses[i] = '0; refb[i] = 1'b0;
        end
        fifo_ptr = 0;
        hand = 0;
        faults = '0;
    endtask

    task automatic shift_down(input int from, input int f);
        for (int i = from; i + 1 < f; i++) begin
            pg[i] = pg[i+1]; vld[i] = vld[i+1]; uses[i] = uses[i+1]; refb[i] = refb[i+1];
        end
    endtask

    // Work out the outcome of one reference and update the frame store.
    task automatic reference_page(input logic [15:0] page, input logic last,
                                  output t_outcome res);
        int f, slot;
        logic hit, vv;
        logic [15:0] vp, keep_pg, keep_cnt;
        f = (nframes < 1) ? 1 : (nframes > NFR) ? NFR : int'(nframes);
        hit = 1'b0; slot = 0; vv = 1'b0; vp = '0;
        for (int i = 0; i < f; i++) begin
            if (!hit && vld[i] && pg[i] == page) begin
                hit = 1'b1; slot = i;
            end
        end
        if (hit) begin
            if (uses[slot] != 16'hFFFF) uses[slot]++;
            refb[slot] = 1'b1;
            if (policy == POL_LRU) begin
                keep_pg = pg[slot]; keep_cnt = uses[slot];
                shift_down(slot, f);
                pg[f-1] = keep_pg; vld[f-1] = 1'b1; uses[f-1] = keep_cnt; refb[f-1] = 1'b1;
            end
        end else begin
            case (policy)
                POL_FIFO: begin
                    slot = (fifo_ptr >= f) ? 0 : fifo_ptr;
                    fifo_ptr = (slot + 1) % f;
                end
                POL_LRU: begin
                    vv = vld[0]; vp = pg[0];
                    shift_down(0, f);
                    slot = f - 1;
                end
                POL_LFU: begin
                    // An empty frame wins; otherwise least use, then smaller page.
                    slot = -1;
                    for (int i = 0; i < f; i++)
                        if (slot < 0 && !vld[i]) slot = i;
                    if (slot < 0) begin
                        slot = 0;
                        for (int i = 1; i < f; i++)
                            if (uses[i] < uses[slot] ||
                                (uses[i] == uses[slot] && pg[i] < pg[slot]))
                                slot = i;
                    end
                end
                default: begin
                    slot = (hand >= f) ? 0 : hand;
                    while (refb[slot]) begin
                        refb[slot] = 1'b0;
                        slot = (slot + 1) % f;
                    end
                    hand = (slot + 1) % f;
                end
            endcase
            if (policy != POL_LRU) begin
                vv = vld[slot]; vp = pg[slot];
            end
            if (!vv) vp = '0;
            pg[slot] = page; vld[slot] = 1'b1; uses[slot] = 16'd1; refb[slot] = 1'b1;
            if (faults != 32'hFFFF_FFFF) faults++;
        end
        res.hit = hit;
        res.victim_valid = vv;
        res.victim_page = vp;
        res.fault_count = faults;
        if (last) clear_frames();
    endtask

    always @(posedge i_clk) begin
        t_outcome got, want;
        if (!i_rst_n) begin
            clear_frames();
            policy = POL_FIFO;
            nframes = 6'd32;
            outcomes_due.delete();
            o_errors <= 0;
            o_hits <= 0;
        end else begin
            if (i_cfg_we) begin
                if (t_cfg_idx'(i_cfg_idx) == CFG_POLICY) policy = t_policy'(i_cfg_data[1:0]);
                else nframes = i_cfg_data;
            end
            if (i_req.valid && i_req.ready) begin
                reference_page(i_req.page_number, i_req.last_reference, want);
                outcomes_due.push_back(want);
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{i_rsp.hit, i_rsp.victim_valid, i_rsp.victim_page, i_rsp.fault_count};
                if (outcomes_due.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: result beat with nothing outstanding", $time);
                    o_errors <= o_errors + 1;
                end else begin
                    want = outcomes_due.pop_front();
                    if (got.hit) o_hits <= o_hits + 1;
                    if (got !== want) begin
                        if (o_errors < 10)
                            $display("%0t: mismatch hit %b/%b victim %b/%b page %h/%h faults %0d/%0d (exp/act)",
                                     $time, want.hit, got.hit, want.victim_valid, got.victim_valid,
                                     want.victim_page, got.victim_page,
                                     want.fault_count, got.fault_count);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= outcomes_due.size();
    end

    final begin
        if (outcomes_due.size() != 0)
            $display("%0d results never arrived", outcomes_due.size());
    end
endmodule
`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives page references, register writes and result back-pressure into the
// page replacement engine; the checker beside it predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import pre_pkg::*;

    // A run stalls only on a bug.
    localparam int STALL_LIMIT = 4000;
    localparam int TARGET_REFS = 1350;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic       cfg_idx;
    logic [5:0] cfg_data;
    int         errors, pending, hits;
    int         refs_sent;
    int         stall_cycles;
    bit         no_idle;

    pre_req_if req ();
    pre_rsp_if rsp ();

    page_replacement_engine_top uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_rsp     (rsp),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    page_replacement_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .i_rsp     (rsp),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .o_errors  (errors),
        .o_pending (pending),
        .o_hits    (hits)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // The receiver stalls about 22 beats in a hundred, except while no_idle is set.
    always @(negedge i_clk) begin
        rsp.ready <= no_idle || ($urandom_range(99) >= 22);
    end

    // Watchdog: any accepted beat or register write counts as progress.
    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Registers are written only with nothing in flight. The extra cycles let
    // a last-reference clear settle after its result beat has gone.
    task automatic write_reg(input t_cfg_idx idx, input logic [5:0] value);
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // One reference beat; valid stays high from one beat to the next unless
    // the sender chooses to idle.
    task automatic send_ref(input logic [15:0] page, input logic last);
        if (!no_idle && $urandom_range(99) < 22) begin
            req.valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        req.valid = 1'b1;
        req.page_number = page;
        req.last_reference = last;
        do @(posedge i_clk); while (!req.ready);
        @(negedge i_clk);
        refs_sent++;
    endtask

    task automatic end_burst();
        req.valid = 1'b0;
    endtask

    initial begin
        int          nref, pool;
        logic [15:0] base, page;
        logic [5:0]  fr;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = 1'b0;
        cfg_data = '0;
        req.valid = 1'b0;
        req.page_number = '0;
        req.last_reference = 1'b0;
        rsp.ready = 1'b0;
        no_idle = 1'b0;
        refs_sent = 0;
        stall_cycles = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part: each policy on four frames with the extreme pages,
        // a repeated page for a hit and enough misses to force an eviction,
        // closing each trace with a last reference.
        write_reg(CFG_FRAMES, 6'd4);
        for (int p = 0; p < 4; p++) begin
            write_reg(CFG_POLICY, 6'(p));
            send_ref(16'h0000, 1'b0);
            send_ref(16'hFFFF, 1'b0);
            send_ref(16'h0001, 1'b0);
            send_ref(16'h0000, 1'b0);
            send_ref(16'h0002, 1'b0);
            send_ref(16'h0003, 1'b1);
            end_burst();
        end
        // Out-of-range frame count zero behaves as one; 63 acts as the maximum in the random phases.
        write_reg(CFG_FRAMES, 6'd0);
        send_ref(16'h0005, 1'b0);
        send_ref(16'h0006, 1'b0);
        send_ref(16'h0006, 1'b1);
        end_burst();

        // Random phases: a small page pool per phase keeps hits frequent,
        // with the occasional wild page so every bit of the page moves.
        while (refs_sent < TARGET_REFS) begin
            case ($urandom_range(8))
                0: fr = 6'd1;
                1: fr = 6'd2;
                2: fr = 6'd32;
                3: fr = 6'd63;
                4: fr = 6'd0;
                default: fr = 6'($urandom_range(3, 12));
            endcase
            write_reg(CFG_POLICY, 6'($urandom_range(3)));
            write_reg(CFG_FRAMES, fr);
            no_idle = ($urandom_range(5) == 0);
            base = 16'($urandom);
            pool = ((fr == 0) ? 1 : (fr > 32) ? 32 : int'(fr)) + $urandom_range(1, 4);
            nref = $urandom_range(60, 120);
            for (int k = 0; k < nref; k++) begin
                if ($urandom_range(19) == 0) page = 16'($urandom);
                else page = base + 16'($urandom_range(pool - 1));
                send_ref(page, $urandom_range(39) == 0);
            end
            end_burst();
        end

        no_idle = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        $display("Sent %0d page references over all four policies and frame counts 0 to 63.",
                 refs_sent);
        $display("%0d results were hits; %0d mismatches seen.", hits, errors);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+src
src/pre_pkg.sv
src/pre_req_if.sv
src/pre_rsp_if.sv
src/pre_store.sv
src/pre_ctrl.sv
src/page_replacement_engine_top.sv
test/page_replacement_checker.sv
test/testbench.sv
